// ===== rtl/ilt_pkg.sv =====
package ilt_pkg;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [9:0] LIMIT_RESET = 10'd510;

    // result kinds
    localparam logic [2:0] K_SKIP      = 3'd0;
    localparam logic [2:0] K_PFX_MARK  = 3'd1;
    localparam logic [2:0] K_PREFIX    = 3'd2;
    localparam logic [2:0] K_COMMAND   = 3'd3;
    localparam logic [2:0] K_MIDDLE    = 3'd4;
    localparam logic [2:0] K_TRL_MARK  = 3'd5;
    localparam logic [2:0] K_TRAILING  = 3'd6;
    localparam logic [2:0] K_STATUS    = 3'd7;

    // line status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_CRLF = 2'd1;
    localparam logic [1:0] ST_NO_SP   = 2'd2;
    localparam logic [1:0] ST_NO_CMD  = 2'd3;

    localparam int RUN_MAX = 4;

    typedef enum logic [2:0] {
        PH_START,
        PH_PREFIX,
        PH_PRECMD,
        PH_COMMAND,
        PH_GAP,
        PH_MIDDLE,
        PH_TRAILING
    } t_phase;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic [7:0] param_number;
        logic [1:0] line_status;
        logic       last_of_run;
    } t_result;

    // all results caused by one accepted byte
    typedef struct packed {
        logic [2:0]                 count;
        t_result [RUN_MAX-1:0]      item;
    } t_run;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] param;
        t_phase     phase;
        logic [7:0] pcnt;
    } t_cls;

    function automatic t_cls classify(input t_phase ph, input logic [7:0] pc,
                                      input logic [7:0] b);
        t_cls r;
        logic crlf;
        r.kind  = K_SKIP;
        r.param = '0;
        r.phase = ph;
        r.pcnt  = pc;
        crlf    = (b == CH_CR) || (b == CH_LF);
        unique case (ph)
            PH_START, PH_PRECMD: begin
                priority if (b == CH_SP) begin
                    r.kind = K_SKIP;
                end else if (ph == PH_START && b == CH_COLON) begin
                    r.kind  = K_PFX_MARK;
                    r.phase = PH_PREFIX;
                end else if (crlf) begin
                    r.kind  = K_MIDDLE;
                    r.param = pc;
                    r.phase = PH_MIDDLE;
                end else begin
                    r.kind  = K_COMMAND;
                    r.phase = PH_COMMAND;
                end
            end
            PH_PREFIX: begin
                if (b == CH_SP) begin
                    r.kind  = K_SKIP;
                    r.phase = PH_PRECMD;
                end else begin
                    r.kind = K_PREFIX;
                end
            end
            PH_COMMAND: begin
                priority if (b == CH_SP) begin
                    r.kind  = K_SKIP;
                    r.phase = PH_GAP;
                end else if (crlf) begin
                    r.kind  = K_MIDDLE;
                    r.param = pc;
                    r.phase = PH_MIDDLE;
                end else begin
                    r.kind = K_COMMAND;
                end
            end
            PH_GAP: begin
                priority if (b == CH_SP) begin
                    r.kind = K_SKIP;
                end else if (b == CH_COLON) begin
                    r.kind  = K_TRL_MARK;
                    r.param = pc;
                    r.phase = PH_TRAILING;
                end else begin
                    r.kind  = K_MIDDLE;
                    r.param = pc;
                    r.phase = PH_MIDDLE;
                end
            end
            PH_MIDDLE: begin
                if (b == CH_SP) begin
                    r.kind  = K_SKIP;
                    r.pcnt  = pc + 8'd1;
                    r.phase = PH_GAP;
                end else begin
                    r.kind  = K_MIDDLE;
                    r.param = pc;
                end
            end
            default: begin
                r.kind  = K_TRAILING;
                r.param = pc;
            end
        endcase
        return r;
    endfunction

    function automatic logic [1:0] phase_status(input t_phase ph);
        logic [1:0] s;
        s = ST_OK;
        if (ph == PH_START || ph == PH_PRECMD) begin
            s = ST_NO_CMD;
        end else if (ph == PH_PREFIX) begin
            s = ST_NO_SP;
        end
        return s;
    endfunction

endpackage

// ===== rtl/ilt_if.sv =====
interface ilt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_line;

    modport source (output valid, output data_byte, output end_of_line, input ready);
    modport sink   (input valid, input data_byte, input end_of_line, output ready);
endinterface

interface ilt_tok_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [7:0] param_number;
    logic [1:0] line_status;
    logic       last_of_run;

    modport source (output valid, output kind, output out_byte, output param_number,
                    output line_status, output last_of_run, input ready);
    modport sink   (input valid, input kind, input out_byte, input param_number,
                    input line_status, input last_of_run, output ready);
endinterface

interface ilt_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] line_limit;

    modport source (output valid, output line_limit, input ready);
    modport sink   (input valid, input line_limit, output ready);
endinterface

// ===== rtl/ilt_out_stage.sv =====
// Holds the run of results of one byte and feeds them out one per transaction
// through an output register.
module ilt_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  ilt_pkg::t_run  i_run,
    output logic           o_room,
    ilt_tok_if.source      o_tok
);

    ilt_pkg::t_result r_item [ilt_pkg::RUN_MAX];
    logic [2:0]       r_rem;
    logic [1:0]       r_pos;
    ilt_pkg::t_result r_out;
    logic             r_out_vld;

    logic move;

    assign move   = (r_rem != 3'd0) && (!r_out_vld || o_tok.ready);
    assign o_room = (r_rem == 3'd0) || ((r_rem == 3'd1) && move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= '0;
            r_pos     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_load) begin
                r_rem <= i_run.count;
                r_pos <= '0;
            end else if (move) begin
                r_rem <= r_rem - 3'd1;
                r_pos <= r_pos + 2'd1;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (o_tok.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int j = 0; j < ilt_pkg::RUN_MAX; j++) begin
                r_item[j] <= i_run.item[j];
            end
        end
        if (move) begin
            r_out <= r_item[r_pos];
        end
    end

    assign o_tok.valid        = r_out_vld;
    assign o_tok.kind         = r_out.kind;
    assign o_tok.out_byte     = r_out.out_byte;
    assign o_tok.param_number = r_out.param_number;
    assign o_tok.line_status  = r_out.line_status;
    assign o_tok.last_of_run  = r_out.last_of_run;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= 3'd4)
        else $error("run count out of range");

    a_move_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_vld)
        else $error("moved result not presented");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_rem == $past(i_run.count)) && (r_pos == 2'd0))
        else $error("run not loaded");

endmodule

// ===== rtl/irc_line_tokenizer.sv =====
// Chat-protocol line tokenizer.
// i_byte: one byte of a line per transaction; end_of_line marks the last byte.
// o_tok: one tagged result per transaction: kind, out_byte, param_number,
//   line_status (with the status kind) and last_of_run on the final result
//   caused by an input byte. A byte causes 0 to 4 results.
// i_cfg: writes line_limit; always ready. Write only while the block is idle.
// The last two bytes of a line are held back until the end is known, so a
// byte's own tag usually leaves two bytes later; the line end flushes them.
// The results of an accepted byte are computed in the accept cycle, loaded
// into the output stage's run hold and moved on through its output register.
// Throughput: one byte per cycle while each byte yields at most one result and
// o_tok does not stall; a byte that yields N results holds i_byte off until
// its run has drained. Set by the single output port.
// Reset: parser back to line start, hold empty, line_limit = 510.
// Stall: when o_tok stalls, bytes are still accepted until one yields results;
// its run waits behind the output register; then i_byte.ready drops.
module irc_line_tokenizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ilt_byte_if.sink  i_byte,
    ilt_tok_if.source o_tok,
    ilt_cfg_if.sink   i_cfg
);

    // line state
    ilt_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_held [2];
    logic [1:0]      r_held_cnt, n_held_cnt;
    logic [9:0]      r_seen, n_seen;
    logic [7:0]      r_param, n_param;
    logic            r_cut, n_cut;
    logic [9:0]      r_limit;

    logic            room;
    logic            accept;
    ilt_pkg::t_run   run;

    // classify chain over the held bytes and the new byte
    logic [7:0]      q   [4];
    ilt_pkg::t_phase st  [5];
    logic [7:0]      pc  [5];
    ilt_pkg::t_cls   cls [4];
    logic [2:0]      m;       // bytes in the sequence (held + new)
    logic [2:0]      k;       // how many of them are classified
    logic [10:0]     seen;
    logic            cutting;
    logic            crlf_ok;
    logic [1:0]      status;

    assign accept      = i_byte.valid && room;
    assign i_byte.ready = room;
    assign i_cfg.ready = 1'b1;

    assign seen    = {1'b0, r_seen} + 11'd1;
    assign cutting = seen >= {1'b0, r_limit};
    assign m       = {1'b0, r_held_cnt} + 3'd1;

    // sequence: held bytes in order, then the new byte
    always_comb begin
        q[0] = (r_held_cnt == 2'd0) ? i_byte.data_byte : r_held[0];
        q[1] = (r_held_cnt == 2'd1) ? i_byte.data_byte : r_held[1];
        q[2] = i_byte.data_byte;
        q[3] = '0;
    end

    // A cut line classifies everything; a plain line end leaves the last two
    // as terminator; a mid-line byte pushes out the oldest when the hold is full.
    always_comb begin
        if (cutting) begin
            k = m;
        end else begin
            k = (r_held_cnt == 2'd2) ? 3'd1 : 3'd0;
        end
    end

    always_comb begin
        st[0] = r_phase;
        pc[0] = r_param;
        for (int j = 0; j < 4; j++) begin
            cls[j] = ilt_pkg::classify(st[j], pc[j], q[j]);
            if (3'(j) < k) begin
                st[j+1] = cls[j].phase;
                pc[j+1] = cls[j].pcnt;
            end else begin
                st[j+1] = st[j];
                pc[j+1] = pc[j];
            end
        end
    end

    // terminator check: the last two bytes of the sequence are CR LF
    always_comb begin
        unique case (r_held_cnt)
            2'd0:    crlf_ok = 1'b0;
            2'd1:    crlf_ok = (r_held[0] == ilt_pkg::CH_CR) &&
                               (i_byte.data_byte == ilt_pkg::CH_LF);
            default: crlf_ok = (r_held[1] == ilt_pkg::CH_CR) &&
                               (i_byte.data_byte == ilt_pkg::CH_LF);
        endcase
        if (cutting || crlf_ok) begin
            status = ilt_pkg::phase_status(st[k]);
        end else begin
            status = ilt_pkg::ST_NO_CRLF;
        end
    end

    // build the run of results and the next line state
    always_comb begin
        run.count  = '0;
        for (int j = 0; j < ilt_pkg::RUN_MAX; j++) begin
            run.item[j] = '0;
        end
        n_phase    = r_phase;
        n_held_cnt = r_held_cnt;
        n_seen     = r_seen;
        n_param    = r_param;
        n_cut      = r_cut;

        priority if (r_cut) begin
            // drop the rest of a cut line
            n_cut = !i_byte.end_of_line;
        end else if (cutting || i_byte.end_of_line) begin
            run.count = m + 3'd1;
            for (int j = 0; j < ilt_pkg::RUN_MAX; j++) begin
                priority if (3'(j) < k) begin
                    run.item[j].kind         = cls[j].kind;
                    run.item[j].out_byte     = q[j];
                    run.item[j].param_number = cls[j].param;
                end else if (3'(j) < m) begin
                    run.item[j].kind     = ilt_pkg::K_SKIP;
                    run.item[j].out_byte = q[j];
                end else if (3'(j) == m) begin
                    run.item[j].kind        = ilt_pkg::K_STATUS;
                    run.item[j].line_status = status;
                    run.item[j].last_of_run = 1'b1;
                end else begin
                    run.item[j] = '0;
                end
            end
            n_phase    = ilt_pkg::PH_START;
            n_held_cnt = '0;
            n_seen     = '0;
            n_param    = '0;
            n_cut      = cutting && !i_byte.end_of_line;
        end else begin
            n_seen = seen[9:0];
            if (r_held_cnt == 2'd2) begin
                run.count                = 3'd1;
                run.item[0].kind         = cls[0].kind;
                run.item[0].out_byte     = q[0];
                run.item[0].param_number = cls[0].param;
                run.item[0].last_of_run  = 1'b1;
                n_phase                  = st[1];
                n_param                  = pc[1];
            end else begin
                n_held_cnt = r_held_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ilt_pkg::PH_START;
            r_held_cnt <= '0;
            r_seen     <= '0;
            r_param    <= '0;
            r_cut      <= 1'b0;
            r_limit    <= ilt_pkg::LIMIT_RESET;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_held_cnt <= n_held_cnt;
                r_seen     <= n_seen;
                r_param    <= n_param;
                r_cut      <= n_cut;
            end
            if (i_cfg.valid) begin
                r_limit <= i_cfg.line_limit;
            end
        end
    end

    // hold line: shift when full, else fill the next slot
    always_ff @(posedge i_clk) begin
        if (accept && !r_cut && !cutting && !i_byte.end_of_line) begin
            if (r_held_cnt == 2'd2) begin
                r_held[0] <= r_held[1];
                r_held[1] <= i_byte.data_byte;
            end else if (r_held_cnt == 2'd1) begin
                r_held[1] <= i_byte.data_byte;
            end else begin
                r_held[0] <= i_byte.data_byte;
            end
        end
    end

    ilt_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_run   (run),
        .o_room  (room),
        .o_tok   (o_tok)
    );

    a_hold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt != 2'd3)
        else $error("hold count out of range");

    a_cut_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cut |-> (r_held_cnt == 2'd0) && (r_seen == 10'd0) &&
                  (r_phase == ilt_pkg::PH_START))
        else $error("line state not cleared while dropping a cut line");

    a_eol_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_byte.end_of_line) |=>
            (r_phase == ilt_pkg::PH_START) && (r_held_cnt == 2'd0) && !r_cut)
        else $error("line end did not restart the parser");

endmodule
